/* rtl/scap_pkg.sv */
// Shared types, codes and ISO 7816-3 lookup tables for the ATR parser.
// Used by scap_step and smart_card_atr_parser; depends on nothing else.
package scap_pkg;

  // Longest ATR accepted, counted from T0 through the last historical byte
  localparam int MAX_ATR_BYTES = 32;
  localparam int CNT_W = $clog2(MAX_ATR_BYTES + 1);

  // Status codes carried in every result item
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BAD_TS   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TCK_ERR  = 3'd4;
  localparam logic [2:0] ST_BAD_PROT = 3'd5;
  localparam logic [2:0] ST_RX_FAULT = 3'd6;

  // Interface byte selectors within a Y nibble
  localparam logic [3:0] SEL_TA = 4'h1;
  localparam logic [3:0] SEL_TB = 4'h2;
  localparam logic [3:0] SEL_TC = 4'h4;
  localparam logic [3:0] SEL_TD = 4'h8;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  localparam logic [3:0] PROT_T0  = 4'd0;
  localparam logic [3:0] PROT_T1  = 4'd1;
  localparam logic [3:0] PROT_T15 = 4'd15;

  // Not-given values of the T=0 / T=1 fields
  localparam logic [8:0] BYTE_NONE   = 9'd256;
  localparam logic [4:0] NIBBLE_NONE = 5'd16;

  typedef enum logic [4:0] {
    PH_TS     = 5'b00001,
    PH_FORMAT = 5'b00010,
    PH_IFACE  = 5'b00100,
    PH_HIST   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] atr_byte;
    logic       rx_fault;
  } in_item_t;

  typedef struct packed {
    logic        reverse_convention;
    logic [11:0] clock_rate_factor;
    logic [6:0]  baud_divisor;
    logic [31:0] max_clock_hz;
    logic [7:0]  extra_guard;
    logic [2:0]  protocol_mask;
    logic [8:0]  wait_integer;
    logic [8:0]  card_frame_size;
    logic [4:0]  block_wait_index;
    logic [4:0]  char_wait_index;
    logic [8:0]  redundancy_type;
  } atr_fields_t;

  typedef struct packed {
    logic [2:0]  status;
    atr_fields_t f;
  } out_item_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       pending;
    logic [5:0]       group_index;
    logic [3:0]       protocol;
    logic [3:0]       hist_remaining;
    logic [7:0]       running_xor;
    logic [CNT_W-1:0] byte_count;
    logic             other_named;
    atr_fields_t      f;
  } parse_state_t;

  function automatic atr_fields_t fields_cleared();
    atr_fields_t r;
    r = '0;
    r.wait_integer     = BYTE_NONE;
    r.card_frame_size  = BYTE_NONE;
    r.block_wait_index = NIBBLE_NONE;
    r.char_wait_index  = NIBBLE_NONE;
    r.redundancy_type  = BYTE_NONE;
    return r;
  endfunction

  function automatic parse_state_t state_reset();
    parse_state_t s;
    s = '0;
    s.phase       = PH_TS;
    s.group_index = 6'd1;
    s.f           = fields_cleared();
    return s;
  endfunction

  // Fi from the upper nibble of TA1
  function automatic logic [11:0] fi_lookup(input logic [3:0] code);
    logic [11:0] r;
    case (code)
      4'd2:    r = 12'd558;
      4'd3:    r = 12'd744;
      4'd4:    r = 12'd1116;
      4'd5:    r = 12'd1488;
      4'd6:    r = 12'd1860;
      4'd9:    r = 12'd512;
      4'd10:   r = 12'd768;
      4'd11:   r = 12'd1024;
      4'd12:   r = 12'd1536;
      4'd13:   r = 12'd2048;
      default: r = 12'd372;
    endcase
    return r;
  endfunction

  // Di from the lower nibble of TA1
  function automatic logic [6:0] di_lookup(input logic [3:0] code);
    logic [6:0] r;
    case (code)
      4'd2:    r = 7'd2;
      4'd3:    r = 7'd4;
      4'd4:    r = 7'd8;
      4'd5:    r = 7'd16;
      4'd6:    r = 7'd32;
      4'd7:    r = 7'd64;
      4'd8:    r = 7'd12;
      4'd9:    r = 7'd20;
      default: r = 7'd1;
    endcase
    return r;
  endfunction

  // fMax from the upper nibble of TA1, all ones for reserved codes
  function automatic logic [31:0] fmax_lookup(input logic [3:0] code);
    logic [31:0] r;
    case (code)
      4'd0:    r = 32'd4000000;
      4'd1:    r = 32'd5000000;
      4'd2:    r = 32'd6000000;
      4'd3:    r = 32'd8000000;
      4'd4:    r = 32'd12000000;
      4'd5:    r = 32'd16000000;
      4'd6:    r = 32'd20000000;
      4'd9:    r = 32'd5000000;
      4'd10:   r = 32'd7500000;
      4'd11:   r = 32'd10000000;
      4'd12:   r = 32'd15000000;
      4'd13:   r = 32'd20000000;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

/* rtl/scap_step.sv */
// Per-character parse logic: next parser state and result item for one ATR byte.
// Purely combinational; uses types, codes and tables from scap_pkg.
module scap_step import scap_pkg::*; (
  input  parse_state_t cur,
  input  in_item_t     item,
  output parse_state_t nxt,
  output out_item_t    res
);

  logic [7:0] b;
  logic [3:0] sel;
  logic       known;
  logic       allowed;
  logic       room;
  logic       iface_done;
  logic       hist_done;
  logic [2:0] status;

  assign b     = item.atr_byte;
  assign room  = cur.byte_count < CNT_W'(MAX_ATR_BYTES);
  assign known = (cur.protocol == PROT_T0) || (cur.protocol == PROT_T1) ||
                 (cur.protocol == PROT_T15);

  // Pick the next expected interface byte by TA, TB, TC, TD priority
  always_comb begin
    if (cur.pending[0]) begin
      sel = SEL_TA;
    end else if (cur.pending[1]) begin
      sel = SEL_TB;
    end else if (cur.pending[2]) begin
      sel = SEL_TC;
    end else begin
      sel = SEL_TD;
    end
  end

  // Reject TA, TB, TC under protocols that give them no defined meaning
  always_comb begin
    case (sel)
      SEL_TA:  allowed = (cur.group_index == 6'd1) || known;
      SEL_TB:  allowed = (cur.group_index <= 6'd2) || known;
      SEL_TC:  allowed = (cur.group_index == 6'd1) || (cur.protocol == PROT_T0) ||
                         (cur.protocol == PROT_T1);
      default: allowed = 1'b1;
    endcase
  end

  // Advance the parser by one character
  always_comb begin
    nxt        = cur;
    status     = ST_BUSY;
    iface_done = 1'b0;
    hist_done  = 1'b0;
    case (cur.phase)
      PH_TS: begin
        nxt.f = fields_cleared();
        if (item.rx_fault) begin
          status = ST_RX_FAULT;
        end else if (b == TS_DIRECT || b == TS_INVERSE) begin
          nxt                      = state_reset();
          nxt.f.reverse_convention = (b == TS_INVERSE);
          nxt.phase                = PH_FORMAT;
        end else begin
          status = ST_BAD_TS;
        end
      end
      PH_FORMAT: begin
        if (item.rx_fault) begin
          status = ST_RX_FAULT;
        end else if (!room) begin
          status = ST_TOO_LONG;
        end else begin
          nxt.byte_count     = cur.byte_count + 1'b1;
          nxt.running_xor    = cur.running_xor ^ b;
          nxt.hist_remaining = b[3:0];
          nxt.pending        = b[7:4];
          nxt.phase          = PH_IFACE;
          iface_done         = (b[7:4] == 4'd0);
        end
      end
      PH_IFACE: begin
        if (item.rx_fault) begin
          status = ST_RX_FAULT;
        end else if (!allowed) begin
          status = ST_BAD_PROT;
        end else if (!room) begin
          status = ST_TOO_LONG;
        end else begin
          nxt.byte_count  = cur.byte_count + 1'b1;
          nxt.running_xor = cur.running_xor ^ b;
          nxt.pending     = cur.pending & ~sel;
          case (sel)
            SEL_TA: begin
              if (cur.group_index == 6'd1) begin
                nxt.f.clock_rate_factor = fi_lookup(b[7:4]);
                nxt.f.baud_divisor      = di_lookup(b[3:0]);
                nxt.f.max_clock_hz      = fmax_lookup(b[7:4]);
              end else if (cur.protocol == PROT_T1 && cur.group_index == 6'd3) begin
                nxt.f.card_frame_size = {1'b0, b};
              end
            end
            SEL_TB: begin
              if (cur.protocol == PROT_T1 && cur.group_index == 6'd3) begin
                nxt.f.block_wait_index = {1'b0, b[7:4]};
                nxt.f.char_wait_index  = {1'b0, b[3:0]};
              end
            end
            SEL_TC: begin
              if (cur.group_index == 6'd1) begin
                nxt.f.extra_guard = b;
              end else if (cur.protocol == PROT_T0 && cur.group_index == 6'd2) begin
                nxt.f.wait_integer = {1'b0, b};
              end else if (cur.protocol == PROT_T1 && cur.group_index == 6'd3) begin
                nxt.f.redundancy_type = {1'b0, b};
              end
            end
            default: begin
              nxt.protocol = b[3:0];
              nxt.pending  = b[7:4];
              if (b[3:0] == PROT_T0) begin
                nxt.f.protocol_mask[0] = 1'b1;
              end
              if (b[3:0] == PROT_T1) begin
                nxt.f.protocol_mask[1] = 1'b1;
              end
              if (b[3:0] == PROT_T15) begin
                nxt.f.protocol_mask[2] = 1'b1;
              end
              if (b[3:0] != PROT_T0) begin
                nxt.other_named = 1'b1;
              end
              if (cur.group_index != 6'd63) begin
                nxt.group_index = cur.group_index + 6'd1;
              end
            end
          endcase
          iface_done = (nxt.pending == 4'd0);
        end
      end
      PH_HIST: begin
        if (item.rx_fault) begin
          status = ST_RX_FAULT;
        end else if (!room) begin
          status = ST_TOO_LONG;
        end else begin
          nxt.byte_count  = cur.byte_count + 1'b1;
          nxt.running_xor = cur.running_xor ^ b;
          if (cur.hist_remaining != 4'd0) begin
            nxt.hist_remaining = cur.hist_remaining - 4'd1;
          end
          hist_done = (nxt.hist_remaining == 4'd0);
        end
      end
      PH_CHECK: begin
        if (item.rx_fault) begin
          status = ST_RX_FAULT;
        end else begin
          status = ((cur.running_xor ^ b) == 8'h00) ? ST_OK : ST_TCK_ERR;
        end
      end
      default: begin
        nxt.phase = PH_TS;
      end
    endcase

    // Leave the interface bytes for the historical bytes or the end
    if (iface_done && nxt.hist_remaining != 4'd0) begin
      nxt.phase = PH_HIST;
    end else if (iface_done || hist_done) begin
      if (nxt.other_named) begin
        nxt.phase = PH_CHECK;
      end else begin
        status = ST_OK;
      end
    end

    // Any final status ends the ATR
    if (status != ST_BUSY) begin
      nxt.phase = PH_TS;
    end
  end

  assign res.status = status;
  assign res.f      = nxt.f;

endmodule

/* rtl/smart_card_atr_parser.sv */
// ISO 7816-3 answer-to-reset parser, top level: state register and output skid.
// Depends on scap_pkg and scap_step.
//
// Usage:
//   in_item carries one received ATR character and a receive-fault flag.
//   Every accepted item yields exactly one out_item: a status and the
//   interface parameters gathered so far (Fi, Di, fMax, N, protocols,
//   WI, IFSC, BWI, CWI, redundancy type).
//   A non-zero status is final; the parser then takes the next character
//   as a new TS.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
// Timing:
//   One character per cycle sustained while in_stall is low. Each result is
//   registered into out_item, or into the skid register when out_item is stalled;
//   the whole parse step sits between the state register and the result register.
//   When the receiver stalls, one more item is taken into a skid register;
//   in_stall rises only while that skid entry is full.
// Reset:
//   rst_n (synchronous, active low) empties the output side and puts the
//   parser in the wait-for-TS state.
module smart_card_atr_parser import scap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  out_item_t    res;
  out_item_t    out_item_r;
  out_item_t    skid_item_r;
  logic         out_valid_r;
  logic         skid_valid_r;
  logic         in_take;
  logic         out_take;

  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  scap_step u_step (
    .cur  (st_r),
    .item (in_item),
    .nxt  (st_nxt),
    .res  (res)
  );

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= state_reset();
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // Result register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_item_r   <= skid_item_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_item_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_item_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Skid entry only holds an item behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  // An item taken while the result is stalled lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("item lost while output stalled");

  // A final status sends the parser back to waiting for TS
  a_final_to_ts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && res.status != ST_BUSY) |=> (st_r.phase == PH_TS))
    else $error("parser did not return to TS after final status");

  // Character count stays within the ATR length bound
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_count <= CNT_W'(MAX_ATR_BYTES))
    else $error("byte count beyond ATR length bound");

endmodule

/* sim/tb_smart_card_atr_parser.sv */
// Self-checking testbench for the ISO 7816-3 ATR parser: a directed stimulus table,
// then random well-formed ATRs with noise, all checked against a built-in predictor.
// Depends on scap_pkg and smart_card_atr_parser.
`timescale 1ns / 100ps

module tb_smart_card_atr_parser;
  import scap_pkg::*;

  // ISO tables indexed by TA1 nibble, code 0 in the top slice
  localparam logic [16*12-1:0] FI_CODES = {
    12'd372, 12'd372, 12'd558, 12'd744, 12'd1116, 12'd1488, 12'd1860, 12'd372,
    12'd372, 12'd512, 12'd768, 12'd1024, 12'd1536, 12'd2048, 12'd372, 12'd372};
  localparam logic [16*7-1:0] DI_CODES = {
    7'd1, 7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd64,
    7'd12, 7'd20, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1};
  localparam logic [16*32-1:0] FMAX_CODES = {
    32'd4000000, 32'd5000000, 32'd6000000, 32'd8000000,
    32'd12000000, 32'd16000000, 32'd20000000, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'd5000000, 32'd7500000, 32'd10000000,
    32'd15000000, 32'd20000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

  localparam int NUM_DIRECTED = 26;

  typedef struct packed {
    logic [7:0] chr;
    logic       fault;
    logic       typed;
    logic [2:0] status;
  } atr_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Run control shared by sender and receiver
  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic long_hold = 1'b0;
  int   failures = 0;

  out_item_t atr_results_due[$];
  in_item_t  atr_chars[$];
  logic [7:0] gen_xor;
  atr_row_t  directed_rows [NUM_DIRECTED];

  // Parser shadow state
  phase_t      atr_phase;
  logic [3:0]  y_pending;
  logic [5:0]  grp_idx;
  logic [3:0]  cur_prot;
  logic [3:0]  hist_left;
  logic [7:0]  xor_acc;
  int          chars_taken;
  bit          tck_needed;
  atr_fields_t atr_info;

  smart_card_atr_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[smart_card_atr_parser] ERROR");
    $finish;
  end

  function automatic atr_fields_t atr_info_none();
    atr_fields_t v;
    v = '0;
    v.wait_integer     = BYTE_NONE;
    v.card_frame_size  = BYTE_NONE;
    v.block_wait_index = NIBBLE_NONE;
    v.char_wait_index  = NIBBLE_NONE;
    v.redundancy_type  = BYTE_NONE;
    return v;
  endfunction

  function automatic void reset_parser();
    atr_phase   = PH_TS;
    y_pending   = '0;
    grp_idx     = 6'd1;
    cur_prot    = PROT_T0;
    hist_left   = '0;
    xor_acc     = '0;
    chars_taken = 0;
    tck_needed  = 1'b0;
    atr_info    = atr_info_none();
  endfunction

  // Count one character toward the length bound and the checksum
  function automatic bit count_char(logic [7:0] c);
    if (chars_taken >= MAX_ATR_BYTES) return 1'b0;
    chars_taken++;
    xor_acc ^= c;
    return 1'b1;
  endfunction

  function automatic logic [2:0] finish_hist();
    if (tck_needed) begin
      atr_phase = PH_CHECK;
      return ST_BUSY;
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] finish_iface();
    if (hist_left != 0) begin
      atr_phase = PH_HIST;
      return ST_BUSY;
    end
    return finish_hist();
  endfunction

  // Advance the shadow parser by one character and return its result item
  function automatic out_item_t parse_atr_char(in_item_t it);
    out_item_t  r;
    logic [2:0] st;
    logic [3:0] sel;
    logic [7:0] b;
    bit         known;
    bit         allowed;
    int         hi;
    int         lo;
    b  = it.atr_byte;
    st = ST_BUSY;
    if (atr_phase == PH_TS) begin
      atr_info = atr_info_none();
      if (it.rx_fault) begin
        st = ST_RX_FAULT;
      end else if (b == TS_DIRECT || b == TS_INVERSE) begin
        reset_parser();
        atr_info.reverse_convention = (b == TS_INVERSE);
        atr_phase = PH_FORMAT;
      end else begin
        st = ST_BAD_TS;
      end
    end else if (it.rx_fault) begin
      st = ST_RX_FAULT;
    end else begin
      case (atr_phase)
        PH_FORMAT: begin
          if (!count_char(b)) begin
            st = ST_TOO_LONG;
          end else begin
            hist_left = b[3:0];
            y_pending = b[7:4];
            atr_phase = PH_IFACE;
            if (y_pending == 0) st = finish_iface();
          end
        end
        PH_IFACE: begin
          // pick the next interface byte in TA, TB, TC, TD order
          if (y_pending[0]) sel = SEL_TA;
          else if (y_pending[1]) sel = SEL_TB;
          else if (y_pending[2]) sel = SEL_TC;
          else sel = SEL_TD;
          known = (cur_prot == PROT_T0 || cur_prot == PROT_T1 || cur_prot == PROT_T15);
          case (sel)
            SEL_TA:  allowed = (grp_idx == 1) || known;
            SEL_TB:  allowed = (grp_idx <= 2) || known;
            SEL_TC:  allowed = (grp_idx == 1) || cur_prot == PROT_T0 || cur_prot == PROT_T1;
            default: allowed = 1'b1;
          endcase
          if (!allowed) begin
            st = ST_BAD_PROT;
          end else if (!count_char(b)) begin
            st = ST_TOO_LONG;
          end else begin
            case (sel)
              SEL_TA: begin
                if (grp_idx == 1) begin
                  hi = 15 - b[7:4];
                  lo = 15 - b[3:0];
                  atr_info.clock_rate_factor = FI_CODES[hi*12 +: 12];
                  atr_info.baud_divisor      = DI_CODES[lo*7 +: 7];
                  atr_info.max_clock_hz      = FMAX_CODES[hi*32 +: 32];
                end else if (cur_prot == PROT_T1 && grp_idx == 3) begin
                  atr_info.card_frame_size = {1'b0, b};
                end
              end
              SEL_TB: begin
                if (cur_prot == PROT_T1 && grp_idx == 3) begin
                  atr_info.block_wait_index = {1'b0, b[7:4]};
                  atr_info.char_wait_index  = {1'b0, b[3:0]};
                end
              end
              SEL_TC: begin
                if (grp_idx == 1) atr_info.extra_guard = b;
                else if (cur_prot == PROT_T0 && grp_idx == 2) atr_info.wait_integer = {1'b0, b};
                else if (cur_prot == PROT_T1 && grp_idx == 3)
                  atr_info.redundancy_type = {1'b0, b};
              end
              default: begin
                cur_prot = b[3:0];
                if (cur_prot == PROT_T0) atr_info.protocol_mask[0] = 1'b1;
                if (cur_prot == PROT_T1) atr_info.protocol_mask[1] = 1'b1;
                if (cur_prot == PROT_T15) atr_info.protocol_mask[2] = 1'b1;
                if (cur_prot != PROT_T0) tck_needed = 1'b1;
                if (grp_idx < 63) grp_idx++;
              end
            endcase
            y_pending = y_pending & ~sel;
            if (sel == SEL_TD) y_pending = b[7:4];
            if (y_pending == 0) st = finish_iface();
          end
        end
        PH_HIST: begin
          if (!count_char(b)) begin
            st = ST_TOO_LONG;
          end else begin
            if (hist_left != 0) hist_left--;
            if (hist_left == 0) st = finish_hist();
          end
        end
        default: st = ((xor_acc ^ b) == 8'h00) ? ST_OK : ST_TCK_ERR;
      endcase
    end
    if (st != ST_BUSY) atr_phase = PH_TS;
    r.status = st;
    r.f      = atr_info;
    return r;
  endfunction

  function automatic void push_char(logic [7:0] c);
    in_item_t it;
    it.atr_byte = c;
    it.rx_fault = ($urandom_range(59) == 0);
    atr_chars.push_back(it);
    gen_xor ^= c;
  endfunction

  // Build one ATR: mostly well formed with random content, sometimes long or noisy
  function automatic void build_random_atr();
    logic [3:0] y;
    logic [3:0] y_next;
    logic [3:0] prot;
    int         groups_max;
    int         grp;
    int         k;
    bit         names_other;
    bit         long_atr;
    atr_chars.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) push_char(8'($urandom));
      return;
    end
    push_char($urandom_range(1) ? TS_INVERSE : TS_DIRECT);
    gen_xor = '0;
    long_atr = ($urandom_range(5) == 0);
    groups_max = long_atr ? 10 : $urandom_range(0, 4);
    if (long_atr) k = $urandom_range(8, 15);
    else if ($urandom_range(3) == 0) k = $urandom_range(0, 15);
    else k = $urandom_range(0, 3);
    y = long_atr ? 4'hF : 4'($urandom);
    if (groups_max == 0) y[3] = 1'b0;
    push_char({y, 4'(k)});
    names_other = 1'b0;
    grp = 1;
    while (y != 0) begin
      if (y[0]) push_char(8'($urandom));
      if (y[1]) push_char(8'($urandom));
      if (y[2]) push_char(8'($urandom));
      if (y[3]) begin
        grp++;
        y_next = long_atr ? 4'hF : 4'($urandom);
        if (grp > groups_max) y_next[3] = 1'b0;
        case ($urandom_range(9))
          0, 1, 2, 3: prot = PROT_T1;
          4, 5, 6:    prot = PROT_T0;
          7, 8:       prot = PROT_T15;
          default:    prot = 4'($urandom_range(2, 14));
        endcase
        if (prot != PROT_T0) names_other = 1'b1;
        push_char({y_next, prot});
        y = y_next;
      end else begin
        y = 4'h0;
      end
    end
    repeat (k) push_char(8'($urandom));
    // corrupt the check character now and then
    if (names_other)
      push_char(($urandom_range(7) == 0) ? (gen_xor ^ 8'($urandom_range(1, 255))) : gen_xor);
  endfunction

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_item(in_item_t it, logic typed, logic [2:0] typed_status);
    out_item_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    want = parse_atr_char(it);
    if (typed) want.status = typed_status;
    atr_results_due.push_back(want);
  endtask

  task automatic run_random_phase(int idle_pct, int stall_pct, int n_items);
    int sent;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      build_random_atr();
      foreach (atr_chars[j]) send_item(atr_chars[j], 1'b0, ST_BUSY);
      sent += atr_chars.size();
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_result();
    out_item_t want;
    if (atr_results_due.size() == 0) begin
      $error("result item arrived with none expected");
      failures++;
    end else begin
      want = atr_results_due.pop_front();
      check_field("status", want.status, out_item.status);
      check_field("reverse_convention", want.f.reverse_convention,
                  out_item.f.reverse_convention);
      check_field("clock_rate_factor", want.f.clock_rate_factor, out_item.f.clock_rate_factor);
      check_field("baud_divisor", want.f.baud_divisor, out_item.f.baud_divisor);
      check_field("max_clock_hz", want.f.max_clock_hz, out_item.f.max_clock_hz);
      check_field("extra_guard", want.f.extra_guard, out_item.f.extra_guard);
      check_field("protocol_mask", want.f.protocol_mask, out_item.f.protocol_mask);
      check_field("wait_integer", want.f.wait_integer, out_item.f.wait_integer);
      check_field("card_frame_size", want.f.card_frame_size, out_item.f.card_frame_size);
      check_field("block_wait_index", want.f.block_wait_index, out_item.f.block_wait_index);
      check_field("char_wait_index", want.f.char_wait_index, out_item.f.char_wait_index);
      check_field("redundancy_type", want.f.redundancy_type, out_item.f.redundancy_type);
    end
  endtask

  // Receiver: check accepted results, then pick the stall for the next cycle
  initial begin : receiver
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
      if (long_hold && hold_count < 400) begin
        hold_count++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    reset_parser();
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, ST_RX_FAULT},  // fault while waiting for TS
      '{8'hFF, 1'b0, 1'b1, ST_BAD_TS},
      '{8'h3F, 1'b0, 1'b1, ST_BUSY},      // inverse convention
      '{8'h00, 1'b0, 1'b1, ST_OK},        // bare T0: T=0 implied, no TCK
      '{8'h3B, 1'b0, 1'b0, ST_BUSY},
      '{8'hF1, 1'b0, 1'b0, ST_BUSY},      // T0: all of group 1, one historical byte
      '{8'hD7, 1'b0, 1'b0, ST_BUSY},      // TA1: largest Fi and Di values
      '{8'h00, 1'b0, 1'b0, ST_BUSY},
      '{8'hFF, 1'b0, 1'b0, ST_BUSY},      // TC1: largest guard time
      '{8'hF1, 1'b0, 1'b0, ST_BUSY},      // TD1: T=1
      '{8'h11, 1'b0, 1'b0, ST_BUSY},
      '{8'h00, 1'b0, 1'b0, ST_BUSY},
      '{8'h00, 1'b0, 1'b0, ST_BUSY},
      '{8'h71, 1'b0, 1'b0, ST_BUSY},      // TD2: T=1, TA3 TB3 TC3 follow
      '{8'hFE, 1'b0, 1'b0, ST_BUSY},
      '{8'h4D, 1'b0, 1'b0, ST_BUSY},
      '{8'h01, 1'b0, 1'b0, ST_BUSY},
      '{8'h80, 1'b0, 1'b0, ST_BUSY},
      '{8'h7A, 1'b0, 1'b1, ST_OK},        // matching TCK
      '{8'h3B, 1'b0, 1'b0, ST_BUSY},
      '{8'h80, 1'b0, 1'b0, ST_BUSY},
      '{8'h12, 1'b0, 1'b0, ST_BUSY},      // TD1 names an unsupported protocol
      '{8'h55, 1'b0, 1'b1, ST_BAD_PROT},  // TA2 under that protocol
      '{8'h3B, 1'b0, 1'b0, ST_BUSY},
      '{8'h80, 1'b0, 1'b0, ST_BUSY},
      '{8'h01, 1'b1, 1'b1, ST_RX_FAULT}   // fault in the middle of an ATR
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed items, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      it.atr_byte = directed_rows[i].chr;
      it.rx_fault = directed_rows[i].fault;
      send_item(it, directed_rows[i].typed, directed_rows[i].status);
    end

    // random ATRs; the first phase also holds off the receiver for a long stretch
    long_hold <= 1'b1;
    run_random_phase(0, 0, 100);
    run_random_phase(87, 0, 100);
    run_random_phase(0, 87, 100);
    run_random_phase(15, 15, 100);
    in_valid <= 1'b0;

    // drain, then allow a few cycles for any stray result
    while (atr_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[smart_card_atr_parser] OK");
    end else begin
      $display("[smart_card_atr_parser] ERROR");
    end
    $finish;
  end

endmodule
